### sv/sec_pkg.sv
package sec_pkg;

   typedef struct packed {
      logic        cmd;
      logic [15:0] src;
      logic [15:0] dst;
   } item_type;

   typedef struct packed {
      logic        hi;
      logic [15:0] sc;
      logic [15:0] dc;
      logic        ovf;
   } result_type;

   localparam logic [23:0] DEG_MAX = 24'hFFFFFF;

   // csr register indexes
   localparam logic [0:0] REG_THRESHOLD  = 1'b0;
   localparam logic [0:0] REG_MAX_VOLUME = 1'b1;

   function automatic logic [23:0] sat_inc24(input logic [23:0] v);
      return (v == DEG_MAX) ? v : v + 24'd1;
   endfunction

endpackage

### sv/streaming_edge_clusterer.sv
// Streaming edge clusterer.
// req_ carries one edge per item: tuser is the command (0 = count degree,
// 1 = cluster), tdata the source vertex (bits 15:0) and destination (31:16).
// rsp_ returns exactly one item per edge, in order: tuser flags a high-degree
// edge, tdata holds source cluster, destination cluster and the sticky id
// overflow flag. csr_ writes degree_threshold (index 0) or max_volume (index 1)
// and is only to be used while no edge is in flight.
// A front register takes one item per cycle while the queue has room,
// reduces vertex ids modulo VERTEX_COUNT and feeds a four-entry queue; a back
// sequencer runs the table updates on single-port memories with registered
// reads. The back finishes each edge, through serial read-modify-write
// accesses to the vertex and volume tables, before it takes the next one from
// the queue. rsp_tvalid is registered and rises once the back reaches its
// output state. After reset all tables are swept to zero with req_tready low.
// A stalled rsp_ holds its item; the front and queue keep accepting until
// they fill.
module streaming_edge_clusterer #(
   parameter int VERTEX_COUNT  = 65536,
   parameter int CLUSTER_SLOTS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // src_vertex, dst_vertex
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // src_cluster, dst_cluster, id_overflow, zero pad
   output logic        rsp_tuser,   // high_degree_edge
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic [23:0] thr_ff, maxv_ff;
   sec_pkg::item_type   in_item, f_item, q_item;
   sec_pkg::result_type res;
   logic q_push, q_full, q_pop, q_valid, clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 24'd0;
         maxv_ff <= 24'd1024;
      end else if (csr_wen) begin
         case (csr_index)
            sec_pkg::REG_THRESHOLD:  thr_ff  <= csr_wdata;
            sec_pkg::REG_MAX_VOLUME: maxv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign in_item.cmd = req_tuser;
   assign in_item.src = req_tdata[15:0];
   assign in_item.dst = req_tdata[31:16];

   sec_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .out_push (q_push),
      .out_full (q_full),
      .out_item (f_item)
   );

   sec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_item)
   );

   sec_back #(.VERTEX_COUNT(VERTEX_COUNT), .CLUSTER_SLOTS(CLUSTER_SLOTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (thr_ff),
      .max_volume (maxv_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (res),
      .clearing   (clearing)
   );

   assign rsp_tuser = res.hi;
   assign rsp_tdata = {7'd0, res.ovf, res.dc, res.sc};

   queue_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into a full queue");

   queue_no_underrun: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from an empty queue");

   sweep_once: assert property (@(posedge clock) disable iff (reset)
      !clearing |=> !clearing) else $error("table sweep restarted");

   degree_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !clearing) else $error("result during sweep");

endmodule

### sv/sec_front.sv
module sec_front #(
   parameter int VERTEX_COUNT = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              in_valid,
   output logic              in_ready,
   input  sec_pkg::item_type in_item,
   output logic              out_push,
   input  logic              out_full,
   output sec_pkg::item_type out_item
);

   // id % VERTEX_COUNT by reciprocal multiply: quotient at accept,
   // remainder on the way into the queue
   localparam int VL = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int SH = 16 + VL;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(VERTEX_COUNT) - 64'd1) / 64'(VERTEX_COUNT);
   localparam logic [17:0] MUL  = 18'(RECIP);
   localparam logic [15:0] NMOD = 16'(VERTEX_COUNT);
   localparam bit          WIDE = (VERTEX_COUNT >= 65536);

   logic              busy_ff, busy_in;
   sec_pkg::item_type item_ff, item_in;
   logic [15:0]       qs_ff, qs_in, qd_ff, qd_in;

   function automatic logic [15:0] vmod_quot(input logic [15:0] x);
      logic [33:0] p;
      p = 34'(x) * 34'(MUL);
      return 16'(p >> SH);
   endfunction

   function automatic logic [15:0] vmod_rem(input logic [15:0] x, input logic [15:0] q);
      logic [31:0] p;
      p = 32'(q) * 32'(NMOD);
      return WIDE ? x : x - p[15:0];
   endfunction

   assign in_ready     = !hold && (!busy_ff || !out_full);
   assign out_push     = busy_ff && !out_full;
   assign out_item.cmd = item_ff.cmd;
   assign out_item.src = vmod_rem(item_ff.src, qs_ff);
   assign out_item.dst = vmod_rem(item_ff.dst, qd_ff);

   always_comb begin
      busy_in = busy_ff;
      item_in = item_ff;
      qs_in   = qs_ff;
      qd_in   = qd_ff;
      if (in_valid && in_ready) begin
         busy_in = 1'b1;
         item_in = in_item;
         qs_in   = vmod_quot(in_item.src);
         qd_in   = vmod_quot(in_item.dst);
      end else if (out_push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      item_ff <= item_in;
      qs_ff   <= qs_in;
      qd_ff   <= qd_in;
   end

endmodule

### sv/sec_fifo.sv
module sec_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sec_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output sec_pkg::item_type pop_item
);

   sec_pkg::item_type slot_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 3'd4);
   assign valid    = (cnt_ff != 3'd0);
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### sv/sec_back.sv
module sec_back #(
   parameter int VERTEX_COUNT  = 65536,
   parameter int CLUSTER_SLOTS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [23:0]         threshold,
   input  logic [23:0]         max_volume,
   input  logic                q_valid,
   input  sec_pkg::item_type   q_item,
   output logic                q_pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output sec_pkg::result_type rsp_data,
   output logic                clearing
);

   localparam int VW   = (VERTEX_COUNT > 2) ? $clog2(VERTEX_COUNT) : 1;
   localparam int CIW  = (CLUSTER_SLOTS > 2) ? $clog2(CLUSTER_SLOTS) : 1;
   localparam int CW   = CIW + 1;
   localparam int MAXN = (VERTEX_COUNT > CLUSTER_SLOTS) ? VERTEX_COUNT : CLUSTER_SLOTS;
   localparam int LW   = (MAXN > 2) ? $clog2(MAXN) : 1;

   localparam logic [4:0] ST_CLEAR = 5'd0,  ST_IDLE = 5'd1,  ST_D0 = 5'd2,  ST_D1 = 5'd3;
   localparam logic [4:0] ST_D2 = 5'd4,     ST_C0 = 5'd5,    ST_C1 = 5'd6,  ST_A0 = 5'd7;
   localparam logic [4:0] ST_A1 = 5'd8,     ST_A2 = 5'd9,    ST_L0 = 5'd10, ST_L1 = 5'd11;
   localparam logic [4:0] ST_L2 = 5'd12,    ST_L3 = 5'd13,   ST_V0 = 5'd14, ST_V1 = 5'd15;
   localparam logic [4:0] ST_V2 = 5'd16,    ST_V3 = 5'd17,   ST_H0 = 5'd18, ST_H1 = 5'd19;
   localparam logic [4:0] ST_H2 = 5'd20,    ST_H3 = 5'd21,   ST_H4 = 5'd22, ST_H5 = 5'd23;
   localparam logic [4:0] ST_M0 = 5'd24,    ST_M1 = 5'd25,   ST_M2 = 5'd26, ST_M3 = 5'd27;
   localparam logic [4:0] ST_M4 = 5'd28,    ST_M5 = 5'd29,   ST_OUT = 5'd30;

   // single-port tables, read data registered
   logic [23:0]  deg_mem  [VERTEX_COUNT];
   logic [23:0]  lsd_mem  [VERTEX_COUNT];
   logic [CIW:0] hcl_mem  [VERTEX_COUNT];
   logic [CIW:0] lcl_mem  [VERTEX_COUNT];
   logic [31:0]  hvol_mem [CLUSTER_SLOTS];
   logic [31:0]  lvol_mem [CLUSTER_SLOTS];

   logic [23:0]  deg_rd_ff, lsd_rd_ff;
   logic [CIW:0] hcl_rd_ff, lcl_rd_ff;
   logic [31:0]  hvol_rd_ff, lvol_rd_ff;

   logic [4:0]         state_ff, state_in;
   logic [LW-1:0]      clr_ff, clr_in;
   sec_pkg::item_type  item_ff, item_in;
   logic               hi_ff, hi_in;
   logic [23:0]        degs_ff, degs_in, degd_ff, degd_in, dg_ff, dg_in;
   logic [CIW-1:0]     cs_ff, cs_in, cd_ff, cd_in, nid_ff, nid_in;
   logic [CIW-1:0]     cmn_ff, cmn_in, cmx_ff, cmx_in;
   logic [31:0]        vs_ff, vs_in, vmx_ff, vmx_in;
   logic               mns_ff, mns_in;
   logic [CW-1:0]      hid_ff, hid_in, lid_ff, lid_in;
   logic               ovf_ff, ovf_in;
   logic               rv_ff, rv_in;
   sec_pkg::result_type rd_ff, rd_in;

   logic [VW-1:0]  vaddr, vtx_s, vtx_d, vtx_mn;
   logic [CIW-1:0] caddr;
   logic           deg_we, lsd_we, cl_we, vol_we, clr;
   logic [23:0]    vwd;
   logic [CIW:0]   clwd;
   logic [31:0]    cwd;
   logic [CIW:0]   cl_rd;
   logic [31:0]    vol_rd;
   logic [CW-1:0]  tk_cur;
   logic           tk_ok;
   logic [CIW-1:0] tk_id;
   logic           mns;

   function automatic logic at_limit(input logic [31:0] v, input logic [23:0] m);
      return $signed({v[31], v}) >= $signed({9'd0, m});
   endfunction

   assign clr       = (state_ff == ST_CLEAR);
   assign clearing  = clr;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
   assign vtx_s     = VW'(item_ff.src);
   assign vtx_d     = VW'(item_ff.dst);
   assign vtx_mn    = mns_ff ? vtx_s : vtx_d;
   assign cl_rd     = hi_ff ? hcl_rd_ff : lcl_rd_ff;
   assign vol_rd    = hi_ff ? hvol_rd_ff : lvol_rd_ff;
   assign tk_cur    = hi_ff ? hid_ff : lid_ff;
   assign tk_ok     = tk_cur < CW'(CLUSTER_SLOTS);
   assign tk_id     = tk_ok ? tk_cur[CIW-1:0] : CIW'(CLUSTER_SLOTS - 1);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      item_in  = item_ff;
      hi_in    = hi_ff;
      degs_in  = degs_ff;
      degd_in  = degd_ff;
      dg_in    = dg_ff;
      cs_in    = cs_ff;
      cd_in    = cd_ff;
      nid_in   = nid_ff;
      cmn_in   = cmn_ff;
      cmx_in   = cmx_ff;
      vs_in    = vs_ff;
      vmx_in   = vmx_ff;
      mns_in   = mns_ff;
      hid_in   = hid_ff;
      lid_in   = lid_ff;
      ovf_in   = ovf_ff;
      rv_in    = rv_ff && !rsp_ready;
      rd_in    = rd_ff;
      q_pop    = 1'b0;
      vaddr    = vtx_s;
      caddr    = cs_ff;
      deg_we   = 1'b0;
      lsd_we   = 1'b0;
      cl_we    = 1'b0;
      vol_we   = 1'b0;
      vwd      = 24'd0;
      clwd     = {1'b1, tk_id};
      cwd      = 32'd0;
      mns      = $signed(vs_ff) < $signed(vol_rd);

      case (state_ff)
         ST_CLEAR: begin
            vaddr = VW'(clr_ff);
            caddr = CIW'(clr_ff);
            clwd  = '0;
            clr_in = clr_ff + LW'(1);
            if (clr_ff == LW'(MAXN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            hi_in = 1'b0;
            vaddr = VW'(q_item.src);
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = q_item.cmd ? ST_C0 : ST_D0;
            end
         end
         ST_D0: begin
            deg_we   = 1'b1;
            vwd      = sec_pkg::sat_inc24(deg_rd_ff);
            state_in = ST_D1;
         end
         ST_D1: begin
            vaddr    = vtx_d;
            state_in = ST_D2;
         end
         ST_D2: begin
            vaddr    = vtx_d;
            deg_we   = 1'b1;
            vwd      = sec_pkg::sat_inc24(deg_rd_ff);
            state_in = ST_OUT;
         end
         ST_C0: begin
            degs_in  = deg_rd_ff;
            vaddr    = vtx_d;
            state_in = ST_C1;
         end
         ST_C1: begin
            degd_in  = deg_rd_ff;
            hi_in    = (degs_ff >= threshold) && (deg_rd_ff >= threshold);
            state_in = ST_A0;
         end
         ST_A0: begin
            if (cl_rd[CIW]) begin
               cs_in = cl_rd[CIW-1:0];
            end else begin
               cs_in = tk_id;
               cl_we = 1'b1;
            end
            state_in = ST_A1;
         end
         ST_A1: begin
            vaddr    = vtx_d;
            state_in = ST_A2;
         end
         ST_A2: begin
            vaddr = vtx_d;
            if (cl_rd[CIW]) begin
               cd_in = cl_rd[CIW-1:0];
            end else begin
               cd_in = tk_id;
               cl_we = 1'b1;
            end
            state_in = hi_ff ? ST_V0 : ST_L0;
         end
         ST_L0: state_in = ST_L1;
         ST_L1: begin
            lsd_we   = 1'b1;
            vwd      = sec_pkg::sat_inc24(lsd_rd_ff);
            state_in = ST_L2;
         end
         ST_L2: begin
            vaddr    = vtx_d;
            state_in = ST_L3;
         end
         ST_L3: begin
            vaddr    = vtx_d;
            lsd_we   = 1'b1;
            vwd      = sec_pkg::sat_inc24(lsd_rd_ff);
            state_in = ST_V0;
         end
         ST_V0: state_in = ST_V1;
         ST_V1: begin
            vol_we   = 1'b1;
            cwd      = vol_rd + 32'd1;
            state_in = ST_V2;
         end
         ST_V2: begin
            caddr    = cd_ff;
            state_in = ST_V3;
         end
         ST_V3: begin
            caddr    = cd_ff;
            vol_we   = 1'b1;
            cwd      = vol_rd + 32'd1;
            state_in = hi_ff ? ST_H0 : ST_M0;
         end
         ST_H0: state_in = ST_H1;
         ST_H1: begin
            state_in = ST_H3;
            if (at_limit(vol_rd, max_volume)) begin
               vol_we = 1'b1;
               cwd    = vol_rd - 32'(degs_ff);
               cl_we  = 1'b1;
               cs_in  = tk_id;
               nid_in = tk_id;
               if (vtx_s == vtx_d) begin
                  cd_in = tk_id;
               end
               state_in = ST_H2;
            end
         end
         ST_H2: begin
            caddr    = nid_ff;
            vol_we   = 1'b1;
            cwd      = 32'(degs_ff);
            state_in = ST_H3;
         end
         ST_H3: begin
            caddr    = cd_ff;
            state_in = ST_H4;
         end
         ST_H4: begin
            caddr    = cd_ff;
            vaddr    = vtx_d;
            state_in = ST_OUT;
            if (at_limit(vol_rd, max_volume)) begin
               vol_we = 1'b1;
               cwd    = vol_rd - 32'(degd_ff);
               cl_we  = 1'b1;
               cd_in  = tk_id;
               nid_in = tk_id;
               if (vtx_s == vtx_d) begin
                  cs_in = tk_id;
               end
               state_in = ST_H5;
            end
         end
         ST_H5: begin
            caddr    = nid_ff;
            vol_we   = 1'b1;
            cwd      = 32'(degd_ff);
            state_in = ST_OUT;
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            vs_in    = vol_rd;
            caddr    = cd_ff;
            state_in = ST_M2;
         end
         ST_M2: begin
            state_in = ST_OUT;
            if (!at_limit(vs_ff, max_volume) && !at_limit(vol_rd, max_volume)) begin
               mns_in   = mns;
               vmx_in   = mns ? vol_rd : vs_ff;
               cmn_in   = mns ? cs_ff : cd_ff;
               cmx_in   = mns ? cd_ff : cs_ff;
               vaddr    = mns ? vtx_s : vtx_d;
               state_in = ST_M3;
            end
         end
         ST_M3: begin
            caddr    = cmx_ff;
            state_in = ST_OUT;
            if ($signed({{2{vmx_ff[31]}}, vmx_ff}) + $signed({10'd0, lsd_rd_ff})
                  <= $signed({10'd0, max_volume})) begin
               dg_in    = lsd_rd_ff;
               vol_we   = 1'b1;
               cwd      = vmx_ff + 32'(lsd_rd_ff);
               state_in = ST_M4;
            end
         end
         ST_M4: begin
            caddr    = cmn_ff;
            state_in = ST_M5;
         end
         ST_M5: begin
            caddr  = cmn_ff;
            vaddr  = vtx_mn;
            vol_we = 1'b1;
            cwd    = vol_rd - 32'(dg_ff);
            cl_we  = 1'b1;
            clwd   = {1'b1, cmx_ff};
            if (vtx_mn == vtx_s) begin
               cs_in = cmx_ff;
            end
            if (vtx_mn == vtx_d) begin
               cd_in = cmx_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rd_in.hi = hi_ff;
               rd_in.sc = item_ff.cmd ? 16'(cs_ff) : 16'd0;
               rd_in.dc = item_ff.cmd ? 16'(cd_ff) : 16'd0;
               rd_in.ovf = ovf_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // id allocation bookkeeping for every cycle that hands out an id
      if (cl_we && !clr && state_ff != ST_M5) begin
         if (!tk_ok) begin
            ovf_in = 1'b1;
         end else if (hi_ff) begin
            hid_in = hid_ff + CW'(1);
         end else begin
            lid_in = lid_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         hid_ff   <= '0;
         lid_ff   <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         hi_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         hid_ff   <= hid_in;
         lid_ff   <= lid_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
         hi_ff    <= hi_in;
      end
      item_ff <= item_in;
      degs_ff <= degs_in;
      degd_ff <= degd_in;
      dg_ff   <= dg_in;
      cs_ff   <= cs_in;
      cd_ff   <= cd_in;
      nid_ff  <= nid_in;
      cmn_ff  <= cmn_in;
      cmx_ff  <= cmx_in;
      vs_ff   <= vs_in;
      vmx_ff  <= vmx_in;
      mns_ff  <= mns_in;
      rd_ff   <= rd_in;
   end

   always_ff @(posedge clock) begin
      if (deg_we || clr) begin
         deg_mem[vaddr] <= vwd;
      end
      deg_rd_ff <= deg_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if (lsd_we || clr) begin
         lsd_mem[vaddr] <= vwd;
      end
      lsd_rd_ff <= lsd_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if ((cl_we && hi_ff) || clr) begin
         hcl_mem[vaddr] <= clwd;
      end
      hcl_rd_ff <= hcl_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if ((cl_we && !hi_ff) || clr) begin
         lcl_mem[vaddr] <= clwd;
      end
      lcl_rd_ff <= lcl_mem[vaddr];
   end

   always_ff @(posedge clock) begin
      if ((vol_we && hi_ff) || clr) begin
         hvol_mem[caddr] <= cwd;
      end
      hvol_rd_ff <= hvol_mem[caddr];
   end

   always_ff @(posedge clock) begin
      if ((vol_we && !hi_ff) || clr) begin
         lvol_mem[caddr] <= cwd;
      end
      lvol_rd_ff <= lvol_mem[caddr];
   end

endmodule
